// ----- rtl/pwo_pkg.sv -----
// Shared types and constants for the phasor waveshape oscillator.
// No dependencies; imported by the controller, datapath and top level.
package pwo_pkg;

  localparam int VOICES_DEF = 2;

  localparam int PH_W     = 24;
  localparam int FRAC_W   = 22;
  localparam int GAIN_W   = 16;
  localparam int SAMPLE_W = 24;
  localparam int CNT_W    = 3;
  localparam int SHAPE_W  = 2;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [FRAC_W:0]   ONE22    = 23'h400000;
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd13107;

  localparam logic [SHAPE_W-1:0] SHAPE_TRI  = 2'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_TONE = 2'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_IMP  = 2'd2;
  localparam logic [SHAPE_W-1:0] SHAPE_NONE = 2'd3;

  localparam logic REG_GAIN = 1'b0;

  typedef struct packed {
    logic load;
    logic square;
    logic shape;
    logic gain;
    logic finish;
  } pwo_cmd_t;

  typedef struct packed {
    logic sq_zero_in;
    logic sq_last;
    logic out_free;
  } pwo_status_t;

endpackage

// ----- rtl/pwo_ctrl.sv -----
// Sequencing state machine for the oscillator: load, square, shape, gain, finish.
// Depends on pwo_pkg for the command and status structs.
module pwo_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output pwo_pkg::pwo_cmd_t    cmd,
  input  pwo_pkg::pwo_status_t status
);
  import pwo_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SQUARE = 5'b00010,
    S_SHAPE  = 5'b00100,
    S_GAIN   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.sq_zero_in ? S_SHAPE : S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        if (status.sq_last) begin
          state_next = S_SHAPE;
        end
      end
      S_SHAPE: begin
        cmd.shape  = 1'b1;
        state_next = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/pwo_datapath.sv -----
// Phase store, shared squaring multiplier, shaper, gain multiplier and output register.
// Depends on pwo_pkg; driven by pwo_ctrl through command and status structs.
module pwo_datapath #(
  parameter int VOICES = pwo_pkg::VOICES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pwo_pkg::pwo_cmd_t                    cmd,
  output pwo_pkg::pwo_status_t                 status,
  input  logic                                 voice,
  input  logic [pwo_pkg::PH_W-1:0]             phase_increment,
  input  logic [pwo_pkg::SHAPE_W-1:0]          shape,
  input  logic [pwo_pkg::CNT_W-1:0]            squarings,
  input  logic [pwo_pkg::GAIN_W-1:0]           gain,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pwo_pkg::SAMPLE_W-1:0]  sample,
  output logic [pwo_pkg::PH_W-1:0]             new_phase
);
  import pwo_pkg::*;

  localparam int SLOTS  = (VOICES > 1) ? 2 : 1;
  localparam int SLOT_W = 1;
  localparam int PROD_W = 2 * PH_W;
  localparam int GMUL_W = (SAMPLE_W + 1) + (GAIN_W + 1);
  localparam int SHR_W  = GMUL_W - GAIN_W;
  localparam logic signed [SHR_W-1:0] SAT_MAX = SHR_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [SHR_W-1:0] SAT_MIN = -SHR_W'(2 ** (SAMPLE_W - 1));

  logic [PH_W-1:0]           phase_q [SLOTS];
  logic [PH_W-1:0]           ph_q;
  logic [PH_W-1:0]           p_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [SHAPE_W-1:0]        shape_q;
  logic [1:0]                quad_q;
  logic [FRAC_W:0]           flip_q;
  logic [FRAC_W:0]           sq_q;
  logic signed [GMUL_W-1:0]  prod_q;

  logic [SLOT_W-1:0]         slot;
  logic [PH_W-1:0]           ph_sum;
  logic [1:0]                quad;
  logic [FRAC_W:0]           frac;
  logic                      do_flip;
  logic [FRAC_W:0]           flip;
  logic [PH_W-1:0]           mul_a;
  logic [PROD_W-1:0]         mul_p;
  logic signed [SAMPLE_W-1:0] g;
  logic signed [SAMPLE_W-1:0] fs;
  logic signed [SAMPLE_W-1:0] ss;
  logic signed [SAMPLE_W-1:0] one_s;
  logic signed [SAMPLE_W:0]   g2;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [GMUL_W-1:0]   gmul;
  logic signed [SHR_W-1:0]    shr;
  logic signed [SAMPLE_W-1:0] sat;

  assign slot   = (SLOTS > 1) ? SLOT_W'(voice) : '0;
  assign ph_sum = phase_q[slot] + phase_increment;

  assign quad = p_q[PH_W-1:PH_W-2];
  assign frac = {1'b0, p_q[FRAC_W-1:0]};

  always_comb begin
    case (shape_q)
      SHAPE_TRI:  do_flip = (quad == 2'd1) || (quad == 2'd2);
      SHAPE_TONE: do_flip = (quad == 2'd0) || (quad == 2'd2);
      SHAPE_IMP:  do_flip = (quad == 2'd1) || (quad == 2'd3);
      default:    do_flip = 1'b0;
    endcase
  end

  assign flip  = do_flip ? (ONE22 - frac) : frac;
  assign mul_a = cmd.square ? p_q : PH_W'(flip);
  assign mul_p = mul_a * mul_a;

  assign fs    = signed'(SAMPLE_W'(flip_q));
  assign ss    = signed'(SAMPLE_W'(sq_q));
  assign one_s = signed'(SAMPLE_W'(ONE22));

  always_comb begin
    case (shape_q)
      SHAPE_TRI:  g = quad_q[1] ? (fs - one_s) : fs;
      SHAPE_TONE: g = quad_q[1] ? (ss - one_s) : (one_s - ss);
      SHAPE_IMP:  g = quad_q[1] ? -ss : ss;
      default:    g = '0;
    endcase
  end

  assign g2     = {g, 1'b0};
  assign gain_s = signed'({1'b0, gain});
  assign gmul   = GMUL_W'(g2) * GMUL_W'(gain_s);

  assign shr = prod_q[GMUL_W-1:GAIN_W];

  always_comb begin
    if (shr > SAT_MAX) begin
      sat = SAT_MAX[SAMPLE_W-1:0];
    end else if (shr < SAT_MIN) begin
      sat = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sat = shr[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        phase_q[i] <= '0;
      end
    end else if (cmd.load) begin
      phase_q[slot] <= ph_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ph_q    <= ph_sum;
      p_q     <= ph_sum;
      cnt_q   <= squarings;
      shape_q <= shape;
    end
    if (cmd.square) begin
      p_q   <= mul_p[PROD_W-1:PH_W];
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (cmd.shape) begin
      flip_q <= flip;
      sq_q   <= mul_p[2*FRAC_W:FRAC_W];
      quad_q <= quad;
    end
    if (cmd.gain) begin
      prod_q <= gmul;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sample    <= sat;
      new_phase <= ph_q;
    end
  end

  assign status.sq_zero_in = (squarings == '0);
  assign status.sq_last    = (cnt_q == CNT_W'(1));
  assign status.out_free   = !out_valid || out_ready;

  a_load_phase: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (ph_q == phase_q[$past(slot)]))
    else $error("stored phase and reported phase disagree after load");

  a_square_count: assert property (@(posedge clk) disable iff (rst)
    cmd.square |-> (cnt_q != '0))
    else $error("squaring issued with no squarings left");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.square |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("squaring count did not step");

  a_no_shape: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && (shape_q == SHAPE_NONE)) |=> (out_valid && (sample == '0)))
    else $error("undefined shape produced a nonzero sample");

endmodule

// ----- rtl/phasor_waveshape_oscillator.sv -----
// Top level: gain register on the APB port, controller and datapath.
// Depends on pwo_pkg, pwo_ctrl and pwo_datapath.
// Each transfer walks load, the squarings in the shared 24x24 squarer, shape, gain and finish;
// out_valid is set by the finish command, which waits while the output register is full.
// A new input is taken while the previous result waits in the output register.
// Reset clears all voice phases to zero and loads the gain with 13107 (0.2).
module phasor_waveshape_oscillator #(
  parameter int VOICES = pwo_pkg::VOICES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 voice,
  input  logic [pwo_pkg::PH_W-1:0]             phase_increment,
  input  logic [pwo_pkg::SHAPE_W-1:0]          shape,
  input  logic [pwo_pkg::CNT_W-1:0]            squarings,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pwo_pkg::SAMPLE_W-1:0]  sample,
  output logic [pwo_pkg::PH_W-1:0]             new_phase,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pwo_pkg::ADDR_W-1:0]           paddr,
  input  logic [pwo_pkg::DATA_W-1:0]           pwdata,
  output logic [pwo_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready
);
  import pwo_pkg::*;

  logic [GAIN_W-1:0] gain;
  logic              reg_index;
  pwo_cmd_t          cmd;
  pwo_status_t       status;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RST;
    end else if (psel && penable && pwrite && pready && (reg_index == REG_GAIN)) begin
      gain <= pwdata[GAIN_W-1:0];
    end
  end

  assign prdata = (reg_index == REG_GAIN) ? DATA_W'(gain) : '0;

  pwo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  pwo_datapath #(
    .VOICES (VOICES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .voice           (voice),
    .phase_increment (phase_increment),
    .shape           (shape),
    .squarings       (squarings),
    .gain            (gain),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sample          (sample),
    .new_phase       (new_phase)
  );

endmodule

// ----- test/phasor_waveshape_oscillator_tb.sv -----
// Testbench for phasor_waveshape_oscillator: random and directed oscillator requests,
// an own phase/shape/gain predictor and an in-order check of every output transfer.
// Depends on pwo_pkg and the phasor_waveshape_oscillator RTL.
module phasor_waveshape_oscillator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwo_pkg::*;

  localparam logic [ADDR_W-1:0] GAIN_ADDR = ADDR_W'(4 * REG_GAIN);
  localparam longint TB_LIMIT = 64'd12 * 64'd200000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [SHAPE_W-1:0] SHAPES [4] = '{SHAPE_TRI, SHAPE_TONE, SHAPE_IMP, SHAPE_NONE};

  typedef struct {
    logic              voice;
    logic [PH_W-1:0]   inc;
    logic [SHAPE_W-1:0] shp;
    logic [CNT_W-1:0]  nsq;
  } osc_request_t;

  typedef struct {
    logic [SAMPLE_W-1:0] smp;
    logic [PH_W-1:0]     ph;
  } osc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic voice = 1'b0;
  logic [PH_W-1:0] phase_increment = '0;
  logic [SHAPE_W-1:0] shape = SHAPE_TRI;
  logic [CNT_W-1:0] squarings = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic [PH_W-1:0] new_phase;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  osc_request_t osc_requests[$];
  osc_result_t  due_results[$];
  logic [PH_W-1:0] model_phase [VOICES_DEF];
  logic [GAIN_W-1:0] model_gain = GAIN_RST;
  int fault_count = 0;
  bit in_xfer = 1'b0;
  int tx_burst = 1;
  int tx_gap = 0;
  int tx_gap_max = 0;
  int rx_hold = 0;
  logic [15:0] rx_pattern = 16'hFFFF;
  logic [3:0] rx_step = '0;

  phasor_waveshape_oscillator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .voice(voice), .phase_increment(phase_increment), .shape(shape), .squarings(squarings),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample(sample), .new_phase(new_phase),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic logic [SAMPLE_W-1:0] shaped_sample(logic [PH_W-1:0] ph,
      logic [SHAPE_W-1:0] shp, logic [CNT_W-1:0] nsq, logic [GAIN_W-1:0] gain);
    logic [PH_W-1:0] p;
    logic [1:0] quad;
    longint one, f, g, prod, s;
    one = longint'(ONE22);
    p = ph;
    for (int k = 0; k < int'(nsq); k++) p = PH_W'((longint'(p) * longint'(p)) >> PH_W);
    quad = p[PH_W-1:FRAC_W];
    f = longint'(p[FRAC_W-1:0]);
    case (shp)
      SHAPE_TRI: begin
        if (quad == 2'd1 || quad == 2'd2) f = one - f;
        if (quad > 2'd1) f = f - one;
        g = f;
      end
      SHAPE_TONE: begin
        if (quad == 2'd0 || quad == 2'd2) f = one - f;
        f = (f * f) >>> FRAC_W;
        g = (quad < 2'd2) ? one - f : f - one;
      end
      SHAPE_IMP: begin
        if (quad == 2'd1 || quad == 2'd3) f = one - f;
        f = (f * f) >>> FRAC_W;
        g = (quad > 2'd1) ? -f : f;
      end
      default: return '0;
    endcase
    prod = g * 2 * longint'(gain);
    s = prod >>> GAIN_W;
    if (s > 64'sd8388607) s = 64'sd8388607;
    if (s < -64'sd8388608) s = -64'sd8388608;
    return SAMPLE_W'(s);
  endfunction

  // Drive input requests in bursts; hold the payload until the transfer.
  always @(negedge clk) begin
    osc_request_t nxt;
    if (in_valid && !in_xfer) begin
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap--;
    end else if (osc_requests.size() != 0) begin
      nxt = osc_requests.pop_front();
      in_valid <= 1'b1;
      voice <= nxt.voice;
      phase_increment <= nxt.inc;
      shape <= nxt.shp;
      squarings <= nxt.nsq;
      if (tx_burst > 1) begin
        tx_burst--;
      end else begin
        tx_burst = $urandom_range(1, 16);
        tx_gap = $urandom_range(0, tx_gap_max);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      out_ready <= rx_pattern[rx_step];
    end
    rx_step <= rx_step + 4'd1;
  end

  always @(posedge clk) begin
    int slot;
    logic [PH_W-1:0] ph;
    osc_result_t want;
    in_xfer = !rst && in_valid && in_ready;
    if (in_xfer) begin
      slot = int'(voice) % VOICES_DEF;
      ph = model_phase[slot] + phase_increment;
      model_phase[slot] = ph;
      due_results.push_back('{shaped_sample(ph, shape, squarings, model_gain), ph});
    end
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("output transfer with no result due: sample %0d new_phase %0h",
               sample, new_phase);
        fault_count++;
      end else begin
        want = due_results.pop_front();
        if (sample !== want.smp) begin
          $error("sample: expected %0d, got %0d", $signed(want.smp), sample);
          fault_count++;
        end
        if (new_phase !== want.ph) begin
          $error("new_phase: expected %0h, got %0h", want.ph, new_phase);
          fault_count++;
        end
      end
    end
  end

  task automatic offer(logic v, logic [PH_W-1:0] inc, logic [SHAPE_W-1:0] shp,
      logic [CNT_W-1:0] nsq);
    osc_requests.push_back('{v, inc, shp, nsq});
  endtask

  task automatic queue_random(int count);
    logic [PH_W-1:0] inc;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: inc = '0;
        1: inc = '1;
        2: inc = PH_W'($urandom_range(1, 255));
        3: inc = {2'($urandom_range(0, 3)), {FRAC_W{1'b0}}};
        default: inc = PH_W'($urandom);
      endcase
      offer(1'($urandom), inc, SHAPES[$urandom_range(0, 3)], CNT_W'($urandom_range(0, 7)));
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (osc_requests.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(logic [GAIN_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= GAIN_ADDR;
    pwdata <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    model_gain = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    logic [GAIN_W-1:0] gains [5];
    gains = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000, GAIN_W'($urandom)};
    foreach (model_phase[i]) model_phase[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int q = 0; q < 4; q++) offer(1'b0, (q == 0) ? '0 : 24'h400000, SHAPE_TRI, '0);
    // wrap by exactly one full turn, back to phase zero
    offer(1'b0, 24'h400000, SHAPE_NONE, '0);
    for (int q = 0; q < 4; q++) offer(1'b1, 24'h400000, SHAPE_TONE, '0);
    for (int q = 0; q < 4; q++) offer(1'b1, 24'h200000, SHAPE_IMP, '0);
    for (int s = 0; s < 8; s++) offer(1'(s), '1, SHAPES[s % 3], CNT_W'(s));
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      write_gain(gains[ph]);
      tx_gap_max = (ph == 1) ? 0 : 5;
      rx_pattern = (ph == 1) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      queue_random(90);
      if (ph == 0) begin
        repeat (4) @(posedge clk);
        rx_hold = 400;
      end
      wait_drained();
    end

    if (fault_count == 0) begin
      $display("phasor_waveshape_oscillator_tb: done, clean");
    end else begin
      $display("phasor_waveshape_oscillator_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(TB_LIMIT);
    $display("phasor_waveshape_oscillator_tb: done, errors");
    $finish;
  end

endmodule

// ----- phasor_waveshape_oscillator.f -----
rtl/pwo_pkg.sv
rtl/pwo_ctrl.sv
rtl/pwo_datapath.sv
rtl/phasor_waveshape_oscillator.sv
test/phasor_waveshape_oscillator_tb.sv
